// File: src/prc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types for the primorial residue checker: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package prc_pkg;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_MUL    = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;         // capture an input transaction
        logic step_reduce;  // one bit of held product mod modulus
        logic reduce_last;  // final reduce bit: move residue to multiplicand
        logic step_mul;     // one bit of double-and-add
        logic commit;       // write running product, load result if last
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;         // current transaction closes a run
        logic out_full;     // result register holds a stalled transaction
    } t_dp_status;

endpackage

// File: src/prc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer for one transaction: accept, reduce the held product bit by bit,
// run the double-and-add multiply bit by bit, then commit.
// ----------------------------------------------------------------------------
module prc_ctrl #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  prc_pkg::t_dp_status    i_status,
    output prc_pkg::t_ctrl_cmd     o_cmd,
    output logic                   o_busy
);
    import prc_pkg::*;

    localparam int CW = $clog2(WORD_WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WORD_WIDTH - 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    // Decode next state, counter and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_LAST;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.step_reduce = 1'b1;
                if (r_cnt == '0) begin
                    o_cmd.reduce_last = 1'b1;
                    n_cnt             = CNT_LAST;
                    n_state           = S_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.step_mul = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                // hold while a result must go out and the output is stalled
                if (!(i_status.last && i_status.out_full)) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state and bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/prc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_datapath
// Running product, operand shift registers and one shared modular
// double-and-add unit, plus the result register.
// ----------------------------------------------------------------------------
module prc_datapath #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  prc_pkg::t_ctrl_cmd      i_cmd,
    output prc_pkg::t_dp_status     o_status,
    input  logic [WORD_WIDTH-1:0]   i_factor,
    input  logic [WORD_WIDTH-1:0]   i_modulus,
    input  logic [31:0]             i_candidate_tag,
    input  logic                    i_first,
    input  logic                    i_last,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [WORD_WIDTH-1:0]   o_remainder,
    output logic                    o_is_minus_one,
    output logic [31:0]             o_result_tag
);
    import prc_pkg::*;

    localparam int W = WORD_WIDTH;

    logic [W-1:0]  r_acc;     // running product
    logic [W-1:0]  r_sh;      // held product, shifted out during reduce
    logic [W-1:0]  r_b;       // factor, shifted out during multiply
    logic [W-1:0]  r_a;       // held product mod modulus
    logic [W-1:0]  r_r;       // partial residue
    logic [W:0]    r_m;       // modulus, zero taken as 2^W
    logic [31:0]   r_tag;
    logic          r_last;

    logic [W-1:0]  addend;
    logic [W+1:0]  sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  sel;
    logic [W-1:0]  n_r;
    logic [W-1:0]  target;

    // Pick the addend: next held-product bit, or multiplicand on a set factor bit
    always_comb begin
        if (i_cmd.step_reduce) begin
            addend = {{(W-1){1'b0}}, r_sh[W-1]};
        end else if (r_b[W-1]) begin
            addend = r_a;
        end else begin
            addend = '0;
        end
    end

    // Double, add, then subtract modulus once or twice; sum stays below 3M
    always_comb begin
        sum = {1'b0, r_r, 1'b0} + {2'b00, addend};
        m1  = {1'b0, r_m};
        m2  = {r_m, 1'b0};
        if (sum >= m2) begin
            sel = sum - m2;
        end else if (sum >= m1) begin
            sel = sum - m1;
        end else begin
            sel = sum;
        end
        n_r = sel[W-1:0];
    end

    // Modulus minus one; a zero-taken-as-2^W modulus gives all ones
    assign target = r_m[W-1:0] - 1'b1;

    // Operand and residue registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m    <= (i_modulus == '0) ? {1'b1, {W{1'b0}}} : {1'b0, i_modulus};
            r_sh   <= i_first ? {{(W-1){1'b0}}, 1'b1} : r_acc;
            r_b    <= i_factor;
            r_r    <= '0;
            r_tag  <= i_candidate_tag;
            r_last <= i_last;
        end else if (i_cmd.step_reduce) begin
            r_sh <= {r_sh[W-2:0], 1'b0};
            if (i_cmd.reduce_last) begin
                r_a <= n_r;
                r_r <= '0;
            end else begin
                r_r <= n_r;
            end
        end else if (i_cmd.step_mul) begin
            r_b <= {r_b[W-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    // Running product, reset to one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= {{(W-1){1'b0}}, 1'b1};
        end else if (i_cmd.commit) begin
            r_acc <= r_r;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_last) begin
            o_remainder    <= r_r;
            o_is_minus_one <= (r_r == target);
            o_result_tag   <= r_tag;
        end
    end

    // Result valid: set on a closing commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.commit && r_last) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_full = o_valid && i_stall;

endmodule

// File: src/primorial_residue_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primorial_residue_checker_unit
// Modular multiply-accumulate of a factor stream with an exact double-width
// reduction; reports the run remainder and whether it equals modulus - 1.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_factor i_modulus i_candidate_tag i_first i_last
//  output    o_valid   i_stall   o_remainder o_is_minus_one o_result_tag
//
//  A transaction is accepted, then the held product is reduced by the modulus,
//  then the double-and-add multiply runs, then the result is committed; all
//  run on a single shared add-and-reduce unit, one bit per cycle.
//  Reset sets the running product to one and empties the result register.
//  A stalled result only holds the commit of a later run-closing transaction.
// ----------------------------------------------------------------------------
module primorial_residue_checker_unit #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [WORD_WIDTH-1:0]  i_factor,
    input  logic [WORD_WIDTH-1:0]  i_modulus,
    input  logic [31:0]            i_candidate_tag,
    input  logic                   i_first,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [WORD_WIDTH-1:0]  o_remainder,
    output logic                   o_is_minus_one,
    output logic [31:0]            o_result_tag
);
    import prc_pkg::*;

    t_ctrl_cmd   cmd;
    t_dp_status  status;

    prc_ctrl #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_stall)
    );

    prc_datapath #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_factor        (i_factor),
        .i_modulus       (i_modulus),
        .i_candidate_tag (i_candidate_tag),
        .i_first         (i_first),
        .i_last          (i_last),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_remainder     (o_remainder),
        .o_is_minus_one  (o_is_minus_one),
        .o_result_tag    (o_result_tag)
    );

endmodule

// File: src/prc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks on the primorial residue checker: busy after accept,
// clean reset, results only from a busy cycle, stalled result holds.
// ----------------------------------------------------------------------------
module prc_checker #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   o_stall,
    input  logic                   o_valid,
    input  logic                   i_stall,
    input  logic [WORD_WIDTH-1:0]  o_remainder,
    input  logic                   o_is_minus_one,
    input  logic [31:0]            o_result_tag
);

    // Accepted transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a transaction");

    // Leave reset idle and empty
    a_reset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_valid && !o_stall))
        else $error("block not idle and empty after reset");

    // New result only follows a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work in progress");

    // Stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_remainder)
            && $stable(o_is_minus_one) && $stable(o_result_tag)))
        else $error("stalled result changed");

endmodule

bind primorial_residue_checker_unit prc_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_prc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_remainder    (o_remainder),
    .o_is_minus_one (o_is_minus_one),
    .o_result_tag   (o_result_tag)
);

// File: tb/sv/prc_residue_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_residue_monitor
// Watches both channels of the primorial residue checker, predicts each run
// remainder from the accepted factor transactions and compares every
// accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module prc_residue_monitor #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // factor channel
    input  logic                   i_valid,
    input  logic                   i_in_stall,
    input  logic [WORD_WIDTH-1:0]  i_factor,
    input  logic [WORD_WIDTH-1:0]  i_modulus,
    input  logic [31:0]            i_candidate_tag,
    input  logic                   i_first,
    input  logic                   i_last,
    // result channel
    input  logic                   i_res_valid,
    input  logic                   i_res_stall,
    input  logic [WORD_WIDTH-1:0]  i_remainder,
    input  logic                   i_is_minus_one,
    input  logic [31:0]            i_result_tag,
    // counts for the testbench top
    output int                     o_error_count,
    output int                     o_pending,
    output int                     o_result_count,
    output int                     o_minus_one_count
);

    typedef struct packed {
        logic [WORD_WIDTH-1:0] remainder;
        logic                  is_minus_one;
        logic [31:0]           tag;
    } t_run_result;

    t_run_result           expected_runs[$];
    logic [WORD_WIDTH-1:0] held_product;
    int                    mismatches;
    int                    results_seen;
    int                    minus_one_seen;

    // Exact (held * factor) mod modulus; modulus zero wraps at the word width
    function automatic logic [WORD_WIDTH-1:0] next_residue(
        input logic [WORD_WIDTH-1:0] held,
        input logic [WORD_WIDTH-1:0] factor,
        input logic [WORD_WIDTH-1:0] modulus
    );
        logic [2*WORD_WIDTH-1:0] wide;
        begin
            if (modulus == '0) begin
                wide = {{WORD_WIDTH{1'b0}}, held} * {{WORD_WIDTH{1'b0}}, factor};
            end else begin
                wide = {{WORD_WIDTH{1'b0}}, held % modulus} *
                       {{WORD_WIDTH{1'b0}}, factor};
                wide = wide % {{WORD_WIDTH{1'b0}}, modulus};
            end
            return wide[WORD_WIDTH-1:0];
        end
    endfunction

    always @(posedge i_clk) begin
        t_run_result           want;
        t_run_result           got;
        logic [WORD_WIDTH-1:0] acc;
        logic [WORD_WIDTH-1:0] target;
        if (!i_rst_n) begin
            held_product   = {{(WORD_WIDTH-1){1'b0}}, 1'b1};
            expected_runs.delete();
            mismatches     = 0;
            results_seen   = 0;
            minus_one_seen = 0;
        end else begin
            // Check the result transaction first: it can never belong to a
            // factor accepted at this same edge
            if (i_res_valid && !i_res_stall) begin
                got.remainder    = i_remainder;
                got.is_minus_one = i_is_minus_one;
                got.tag          = i_result_tag;
                results_seen++;
                if (expected_runs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result rem=%h flag=%b tag=%h",
                                 $realtime, got.remainder, got.is_minus_one, got.tag);
                end else begin
                    want = expected_runs.pop_front();
                    if (want.is_minus_one)
                        minus_one_seen++;
                    if (got.remainder !== want.remainder ||
                        got.is_minus_one !== want.is_minus_one ||
                        got.tag !== want.tag) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch exp rem=%h flag=%b tag=%h,",
                                     $realtime, want.remainder, want.is_minus_one,
                                     want.tag, " got rem=%h flag=%b tag=%h",
                                     got.remainder, got.is_minus_one, got.tag);
                    end
                end
            end

            // Advance the running product on each accepted factor transaction
            if (i_valid && !i_in_stall) begin
                acc = i_first ? {{(WORD_WIDTH-1){1'b0}}, 1'b1} : held_product;
                acc = next_residue(acc, i_factor, i_modulus);
                target = (i_modulus == '0) ? {WORD_WIDTH{1'b1}} : i_modulus - 1'b1;
                held_product = acc;
                if (i_last) begin
                    want.remainder    = acc;
                    want.is_minus_one = (acc == target);
                    want.tag          = i_candidate_tag;
                    expected_runs.push_back(want);
                end
            end
        end
        o_error_count     <= mismatches;
        o_pending         <= expected_runs.size();
        o_result_count    <= results_seen;
        o_minus_one_count <= minus_one_seen;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives factor runs into the primorial residue checker: a short directed
// set of edge cases, then random runs (Wilson runs over small primes, wrap
// and unit moduli, mid-run modulus changes, broken runs), with random gaps
// on the sender and random stalls on the receiver. Verdict from the monitor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WORD_WIDTH   = 64;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_CYCLES  = 2 * (2 * WORD_WIDTH + 2) + 100;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_stall;
    logic [WORD_WIDTH-1:0] i_factor        = '0;
    logic [WORD_WIDTH-1:0] i_modulus       = '0;
    logic [31:0]           i_candidate_tag = '0;
    logic                  i_first         = 1'b0;
    logic                  i_last          = 1'b0;
    logic                  o_valid;
    logic                  i_stall         = 1'b0;
    logic [WORD_WIDTH-1:0] o_remainder;
    logic                  o_is_minus_one;
    logic [31:0]           o_result_tag;

    int   error_count;
    int   pending;
    int   result_count;
    int   minus_one_count;
    int   items_sent  = 0;
    int   stall_burst = 0;
    logic calm        = 1'b0;

    always #2 i_clk = ~i_clk;

    primorial_residue_checker_unit #(
        .WORD_WIDTH (WORD_WIDTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_factor        (i_factor),
        .i_modulus       (i_modulus),
        .i_candidate_tag (i_candidate_tag),
        .i_first         (i_first),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_remainder     (o_remainder),
        .o_is_minus_one  (o_is_minus_one),
        .o_result_tag    (o_result_tag)
    );

    prc_residue_monitor #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_in_stall        (o_stall),
        .i_factor          (i_factor),
        .i_modulus         (i_modulus),
        .i_candidate_tag   (i_candidate_tag),
        .i_first           (i_first),
        .i_last            (i_last),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_remainder       (o_remainder),
        .i_is_minus_one    (o_is_minus_one),
        .i_result_tag      (o_result_tag),
        .o_error_count     (error_count),
        .o_pending         (pending),
        .o_result_count    (result_count),
        .o_minus_one_count (minus_one_count)
    );

    // Stall the result channel at random, with occasional long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_burst = 0;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_burst > 0) begin
            stall_burst--;
            i_stall <= 1'b1;
        end else begin
            if ($urandom_range(999) < 4)
                stall_burst = $urandom_range(20, 300);
            i_stall <= ($urandom_range(99) < 26);
        end
    end

    function automatic logic [63:0] urand64();
        return {$urandom, $urandom};
    endfunction

    // Pick a factor for modulus m: mostly reduced, sometimes raw or extreme
    function automatic logic [63:0] pick_factor(input logic [63:0] m);
        logic [63:0] r;
        int          sel;
        begin
            r   = urand64();
            sel = $urandom_range(99);
            if (sel < 5)
                return 64'd0;
            if (sel < 10)
                return 64'd1;
            if (sel < 15)
                return m - 64'd1;
            if (sel < 35 || m == 64'd0)
                return r;
            return r % m;
        end
    endfunction

    function automatic logic [63:0] pick_modulus();
        int sel;
        begin
            sel = $urandom_range(99);
            if (sel < 33)
                return urand64();
            if (sel < 50)
                return 64'($urandom_range(2, 65535));
            if (sel < 61)
                return 64'd0 - 64'($urandom_range(0, 1000));
            if (sel < 70)
                return 64'd1 << $urandom_range(1, 63);
            if (sel < 76)
                return 64'd0;
            if (sel < 80)
                return 64'd1;
            return {32'd0, $urandom} | 64'd2;
        end
    endfunction

    // Present one factor transaction and hold it until accepted
    task automatic push_factor(input logic [63:0] factor, input logic [63:0] modulus,
                               input logic [31:0] tag, input logic is_first,
                               input logic is_last);
        begin
            i_valid         <= 1'b1;
            i_factor        <= factor;
            i_modulus       <= modulus;
            i_candidate_tag <= tag;
            i_first         <= is_first;
            i_last          <= is_last;
            @(posedge i_clk);
            while (o_stall)
                @(posedge i_clk);
            items_sent++;
        end
    endtask

    // Idle the sender for a random number of cycles, sometimes a long gap
    task automatic sender_gap();
        int n;
        begin
            n = 0;
            if (!calm) begin
                while ($urandom_range(99) < 26)
                    n++;
                if ($urandom_range(99) < 3)
                    n += $urandom_range(1, 160);
            end
            if (n > 0) begin
                i_valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    task automatic send(input logic [63:0] factor, input logic [63:0] modulus,
                        input logic [31:0] tag, input logic is_first, input logic is_last);
        begin
            push_factor(factor, modulus, tag, is_first, is_last);
            sender_gap();
        end
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_results_drained();
        begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic directed_items();
        begin
            // Product held from reset is one
            send(64'd5, 64'd7, 32'd0, 1'b0, 1'b1);
            // Largest factor and modulus
            send('1, '1, 32'hFFFF_FFFF, 1'b1, 1'b1);
            send(64'hFFFF_FFFF_FFFF_FFFE, '1, 32'h1, 1'b1, 1'b1);
            // Modulus zero wraps at the word width
            send('1, 64'd0, 32'h2, 1'b1, 1'b0);
            send(64'd1, 64'd0, 32'h2, 1'b0, 1'b1);
            send(64'h8000_0000_0000_0000, 64'd0, 32'h3, 1'b1, 1'b0);
            send(64'h8000_0000_0000_0000, 64'd0, 32'h3, 1'b0, 1'b1);
            // Modulus one gives zero, which is modulus minus one
            send(64'h1234_5678_9ABC_DEF0, 64'd1, 32'h4, 1'b1, 1'b1);
            send(64'd0, 64'd2, 32'h5, 1'b1, 1'b1);
            // Factor above the modulus
            send('1, 64'd1000003, 32'h6, 1'b1, 1'b1);
            // Full double-width products near the top
            send(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFC5, 32'h7, 1'b1, 1'b0);
            send(64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_FFFF_FFC5, 32'h7, 1'b0, 1'b0);
            send(64'hFFFF_FFFF_FFFF_FFC4, 64'hFFFF_FFFF_FFFF_FFC5, 32'h7, 1'b0, 1'b1);
            // Modulus changed inside a run
            send(64'hDEAD_BEEF_CAFE_F00D, 64'hFFFF_FFFF_FFFF_FFC5, 32'h8, 1'b1, 1'b0);
            send(64'd3, 64'd97, 32'h8, 1'b0, 1'b1);
            // Wilson run for seven: six factorial is minus one mod seven
            for (int k = 1; k < 7; k++)
                send(64'(k), 64'd7, 32'h9, k == 1, k == 6);
        end
    endtask

    task automatic random_run();
        int unsigned small_primes[9] = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
        logic [63:0] modulus;
        logic [31:0] tag;
        int          sel;
        int          len;
        int          p;
        begin
            sel = $urandom_range(99);
            tag = (sel < 3) ? 32'd0 : (sel < 6) ? 32'hFFFF_FFFF : $urandom;
            if ($urandom_range(99) < 14) begin
                // Wilson run over a small prime
                p = small_primes[$urandom_range(8)];
                for (int k = 1; k < p; k++)
                    send(64'(k), 64'(p), tag, k == 1, k == p - 1);
            end else begin
                modulus = pick_modulus();
                len     = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    sel = $urandom_range(99);
                    if (sel < 5) begin
                        // Noise transaction with arbitrary marks
                        send(urand64(), urand64(), $urandom,
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                    end else begin
                        if (sel < 10 && k > 0)
                            modulus = pick_modulus();
                        send(pick_factor(modulus), modulus, tag,
                             (k == 0) && ($urandom_range(99) < 93),
                             (k == len - 1) && ($urandom_range(99) < 93));
                    end
                end
            end
        end
    endtask

    // Bound the run: far beyond the slowest legal pass
    initial begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int directed_count;
        logic pressure_done;
        pressure_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        directed_count = items_sent;
        wait_results_drained();

        while (items_sent < directed_count + RANDOM_ITEMS) begin
            if (!pressure_done && items_sent > directed_count + RANDOM_ITEMS / 2) begin
                wait_results_drained();
                pressure_done = 1'b1;
            end
            calm <= (items_sent > directed_count + 300) &&
                    (items_sent < directed_count + 450);
            random_run();
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d factor transactions; checked %0d run results, %0d of them minus one.",
                 items_sent, result_count, minus_one_count);
        if (error_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
